FILE: sv/spq_pkg.sv
// shared types, constants and codes for the sorted priority queue
package spq_pkg;

	localparam int SPQ_CAPACITY = 128;
	localparam int KEY_W        = 32;
	localparam int VALUE_W      = 64;
	localparam int STATUS_W     = 2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// double-precision negative infinity
	localparam logic [VALUE_W-1:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [VALUE_W-1:0]      value;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic start;        // capture the transaction, prime the first read
		logic is_insert;    // kind of transaction being started
		logic reject_full;
		logic reject_empty;
		logic shift;        // move one entry up a slot
		logic place;        // write the new entry into the hole
		logic take;         // pop the head entry
		logic publish;      // move the pending result to the output register
	} spq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic shift_needed;
		logic out_free;
	} spq_stat_t;

endpackage

FILE: sv/spq_if.sv
// request and response channel interfaces
interface spq_req_if;
	import spq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic signed [KEY_W-1:0] item_key;
	logic [VALUE_W-1:0]      item_value;

	modport source (output valid, output operation, output item_key, output item_value,
		input ready);
	modport sink (input valid, input operation, input item_key, input item_value,
		output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  out_value;

	modport source (output valid, output status, output out_value, input ready);
	modport sink (input valid, input status, input out_value, output ready);
endinterface

FILE: sv/sorted_priority_queue.sv
// top level of the sorted min-priority queue
// bounded min-priority queue of (signed key, 64-bit payload) entries in key order.
// req channel: operation (insert or extract), item_key, item_value.
// rsp channel: status (ok, full, empty) and out_value, one per request transaction.
// an insert lands ahead of all entries with an equal or greater key, so equal keys
// leave newest first. an extract returns the head payload, or the negative infinity
// pattern with status empty when nothing is stored. a full insert changes nothing.
// entries live in a single-port-write, single-port-read memory used as a ring: the
// head moves on extract, and an insert walks down from the tail moving one entry a
// cycle through that memory port until the hole reaches its place.
// an accepted insert shifts each entry that must move and then places the new one;
// an extract takes the head; a full or empty rejection goes straight to the result.
// one transaction is worked on at a time; the next one is taken once the response is
// loaded into the output register and the controller is idle again.
// a response waits in the output register while the receiver stalls; the following
// transaction is still taken and finished, then holds until that register frees up.
// reset empties the queue at once; memory contents are not cleared.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = SPQ_CAPACITY
)(
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.item_key   (req.item_key),
		.item_value (req.item_value),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_value  (rsp.out_value)
	);

endmodule

FILE: sv/spq_ctrl.sv
// sequencing state machine for insert and extract transactions
module spq_ctrl
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_operation,
	output logic      req_ready,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_INS  = 4'b0010,
		S_EXT  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start     = 1'b1;
					cmd.is_insert = (req_operation == OP_INSERT);
					if (req_operation == OP_INSERT) begin
						if (stat.full) begin
							cmd.reject_full = 1'b1;
							state_d         = S_DONE;
						end else begin
							state_d = S_INS;
						end
					end else begin
						if (stat.empty) begin
							cmd.reject_empty = 1'b1;
							state_d          = S_DONE;
						end else begin
							state_d = S_EXT;
						end
					end
				end
			end
			S_INS: begin
				if (stat.shift_needed) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_DONE;
				end
			end
			S_EXT: begin
				cmd.take = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/spq_datapath.sv
// entry memory kept as a sorted ring, with count, head pointer and result registers
module spq_datapath
	import spq_pkg::*;
#(
	parameter int CAPACITY = SPQ_CAPACITY
)(
	input  logic                    clk,
	input  logic                    arst_n,
	input  spq_cmd_t                cmd,
	output spq_stat_t               stat,
	input  logic signed [KEY_W-1:0] item_key,
	input  logic [VALUE_W-1:0]      item_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STATUS_W-1:0]     out_status,
	output logic [VALUE_W-1:0]      out_value
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OFS_W = CNT_W + 2;

	// logical slot (head-relative, may be slightly negative) to memory address
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
			input logic signed [OFS_W-1:0] ofs);
		logic signed [OFS_W-1:0] sum;
		sum = $signed(OFS_W'(head)) + ofs;
		if (sum < 0) begin
			sum = sum + $signed(OFS_W'(CAPACITY));
		end else if (sum >= $signed(OFS_W'(CAPACITY))) begin
			sum = sum - $signed(OFS_W'(CAPACITY));
		end
		return sum[IDX_W-1:0];
	endfunction

	entry_t entry_mem_q [CAPACITY];
	entry_t rd_data_q;

	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VALUE_W-1:0]      val_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [VALUE_W-1:0]      res_value_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [VALUE_W-1:0]      out_value_q;

	logic                    rd_en;
	logic signed [OFS_W-1:0] rd_ofs;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	entry_t                  wr_data;
	logic [IDX_W-1:0]        head_inc;

	assign stat.full         = (count_q == CNT_W'(CAPACITY));
	assign stat.empty        = (count_q == '0);
	// entries at or above the new key move up one slot, working down from the tail
	assign stat.shift_needed = (pos_q != '0) && (rd_data_q.key >= key_q);
	assign stat.out_free     = !out_valid_q || out_ready;

	always_comb begin
		rd_en  = cmd.start || cmd.shift;
		rd_ofs = '0;
		if (cmd.start) begin
			if (cmd.is_insert) begin
				rd_ofs = $signed(OFS_W'(count_q)) - $signed(OFS_W'(1));
			end
		end else begin
			rd_ofs = $signed(OFS_W'(pos_q)) - $signed(OFS_W'(2));
		end
		rd_addr = phys(head_q, rd_ofs);
	end

	assign wr_en   = cmd.shift || cmd.place;
	assign wr_addr = phys(head_q, $signed(OFS_W'(pos_q)));
	assign wr_data = cmd.shift ? rd_data_q : entry_t'{key: key_q, value: val_q};

	assign head_inc = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= item_key;
			val_q <= item_value;
		end
		if (cmd.reject_full || cmd.place) begin
			res_status_q <= cmd.place ? ST_OK : ST_FULL;
			res_value_q  <= '0;
		end else if (cmd.reject_empty) begin
			res_status_q <= ST_EMPTY;
			res_value_q  <= NEG_INF_BITS;
		end else if (cmd.take) begin
			res_status_q <= ST_OK;
			res_value_q  <= rd_data_q.value;
		end
		if (cmd.publish) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				pos_q <= count_q;
			end else if (cmd.shift) begin
				pos_q <= pos_q - 1'b1;
			end
			if (cmd.place) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.take) begin
				count_q <= count_q - 1'b1;
				head_q  <= head_inc;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;

endmodule

FILE: sv/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker
	import spq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [VALUE_W-1:0]  rsp_value
);

	// a waiting response is not withdrawn
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL ||
			rsp_status == ST_EMPTY))
		else $error("undefined status code");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_value == '0)
		else $error("full response carries a payload");

	a_empty_neginf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_value == NEG_INF_BITS)
		else $error("empty response without negative infinity");

	// one transaction in flight: no new request taken in the cycle a response is loaded
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("request taken while response was being loaded");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_value  (rsp.out_value)
);

FILE: tb/sv/sorted_priority_queue_tb.sv
// self-checking testbench for the sorted min-priority queue
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int QCAP        = SPQ_CAPACITY;
	localparam int DIR_ROWS    = 23;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCS = 200;
	localparam int DRAIN_LIMIT = 200000;
	localparam int MAX_SHOWN   = 10;

	typedef struct packed {
		logic                    op;
		logic signed [KEY_W-1:0] key;
		logic [VALUE_W-1:0]      value;
		logic                    fixed_exp;
		logic [STATUS_W-1:0]     st;
		logic [VALUE_W-1:0]      ov;
	} stim_row_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
	} queue_result_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue #(.CAPACITY(QCAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the queue, head in slot 0
	logic signed [KEY_W-1:0] shadow_keys [QCAP];
	logic [VALUE_W-1:0]      shadow_vals [QCAP];
	int                      shadow_count;

	queue_result_t awaited_results [$];

	int mismatches;
	int n_insert, n_extract, n_full, n_empty, peak_fill;
	int tx_idle_pct, rx_idle_pct;
	bit hold_req;

	// directed transactions: boundaries, equal keys, empty and ignored fields on extract
	stim_row_t stim_table [0:DIR_ROWS-1] = '{
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b1, ST_EMPTY, NEG_INF_BITS},
		'{OP_INSERT, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sh8000_0000, 64'h0, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sd0, 64'h1, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sd0, 64'h2, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, -32'sd1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b1, ST_EMPTY, NEG_INF_BITS},
		'{OP_INSERT, 32'sd5, 64'h5555_5555_5555_5555, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sd5, 64'h0123_4567_89AB_CDEF, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sd5, 64'hFEDC_BA98_7654_3210, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sh7FFF_FFFF, 64'h1, 1'b1, ST_OK, 64'd0},
		'{OP_INSERT, 32'sh8000_0000, 64'h2, 1'b1, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sd0, 64'd0, 1'b0, ST_OK, 64'd0},
		'{OP_EXTRACT, 32'sh8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_EMPTY,
			NEG_INF_BITS}
	};

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void predict_queue_op(input logic op, input logic signed [KEY_W-1:0] k,
		input logic [VALUE_W-1:0] v, output logic [STATUS_W-1:0] st,
		output logic [VALUE_W-1:0] ov);
		int  pos;
		bit  found;
		if (op == OP_INSERT) begin
			ov = '0;
			if (shadow_count >= QCAP) begin
				st = ST_FULL;
			end else begin
				st = ST_OK;
				pos = shadow_count;
				found = 1'b0;
				// new entry goes ahead of every key greater or equal
				for (int i = 0; i < shadow_count; i++) begin
					if (!found && shadow_keys[i] >= k) begin
						pos = i;
						found = 1'b1;
					end
				end
				for (int i = shadow_count; i > pos; i--) begin
					shadow_keys[i] = shadow_keys[i-1];
					shadow_vals[i] = shadow_vals[i-1];
				end
				shadow_keys[pos] = k;
				shadow_vals[pos] = v;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			st = ST_EMPTY;
			ov = NEG_INF_BITS;
		end else begin
			st = ST_OK;
			ov = shadow_vals[0];
			for (int i = 1; i < shadow_count; i++) begin
				shadow_keys[i-1] = shadow_keys[i];
				shadow_vals[i-1] = shadow_vals[i];
			end
			shadow_count--;
		end
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return {1'b1, {(KEY_W-1){1'b0}}};
			1: return {1'b0, {(KEY_W-1){1'b1}}};
			2, 3, 4: return KEY_W'($urandom_range(6)) - KEY_W'(3);
			5: return {1'b1, {(KEY_W-1){1'b0}}} + KEY_W'($urandom_range(3));
			6: return {1'b0, {(KEY_W-1){1'b1}}} - KEY_W'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return NEG_INF_BITS;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// offer one transaction, wait for acceptance, then record what should come back
	task automatic issue_request(input logic op, input logic signed [KEY_W-1:0] k,
		input logic [VALUE_W-1:0] v, input bit fixed_exp, input logic [STATUS_W-1:0] st_fixed,
		input logic [VALUE_W-1:0] ov_fixed, output logic [STATUS_W-1:0] st_pred);
		logic [VALUE_W-1:0] ov_pred;
		queue_result_t      res;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.item_key   <= k;
		req_ch.item_value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_queue_op(op, k, v, st_pred, ov_pred);
		res.status = fixed_exp ? st_fixed : st_pred;
		res.value  = fixed_exp ? ov_fixed : ov_pred;
		awaited_results.push_back(res);
		if (op == OP_INSERT) begin
			n_insert++;
			if (st_pred == ST_FULL)
				n_full++;
		end else begin
			n_extract++;
			if (st_pred == ST_EMPTY)
				n_empty++;
		end
		if (shadow_count > peak_fill)
			peak_fill = shadow_count;
	endtask

	task automatic wait_all_returned();
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_mix(input int n_items);
		int                  ins_pct;
		logic [STATUS_W-1:0] st;
		for (int j = 0; j < n_items; j++) begin
			// bias shifts every score of transactions so the fill level wanders
			if (j % 20 == 0) begin
				case ($urandom_range(3))
					0, 1: ins_pct = 80;
					2: ins_pct = 50;
					default: ins_pct = 20;
				endcase
			end
			issue_request(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT, pick_key(),
				pick_value(), 1'b0, ST_OK, '0, st);
		end
	endtask

	// response side: random back-pressure plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		queue_result_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected response status %0d value %h",
					rsp_ch.status, rsp_ch.out_value));
			end else begin
				exp_res = awaited_results.pop_front();
				if (rsp_ch.status !== exp_res.status)
					flag_mismatch($sformatf("status expected %0d got %0d",
						exp_res.status, rsp_ch.status));
				if (rsp_ch.out_value !== exp_res.value)
					flag_mismatch($sformatf("out_value expected %h got %h",
						exp_res.value, rsp_ch.out_value));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [STATUS_W-1:0] st;
		int                  refusals;
		int                  waited;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.operation   = OP_INSERT;
		req_ch.item_key    = '0;
		req_ch.item_value  = '0;
		hold_req           = 1'b0;
		shadow_count       = 0;
		mismatches         = 0;
		n_insert           = 0;
		n_extract          = 0;
		n_full             = 0;
		n_empty            = 0;
		peak_fill          = 0;
		tx_idle_pct        = 15;
		rx_idle_pct        = 88;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			issue_request(stim_table[r].op, stim_table[r].key, stim_table[r].value,
				stim_table[r].fixed_exp, stim_table[r].st, stim_table[r].ov, st);

		random_mix(140);
		wait_all_returned();

		tx_idle_pct = 88;
		rx_idle_pct = 15;
		random_mix(140);
		wait_all_returned();

		// no idling: long response hold-off while the queue is driven to full
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b1;
		refusals    = 0;
		while (refusals < 4) begin
			issue_request(OP_INSERT, pick_key(), pick_value(), 1'b0, ST_OK, '0, st);
			if (st == ST_FULL)
				refusals++;
		end
		issue_request(OP_EXTRACT, '0, '0, 1'b0, ST_OK, '0, st);
		issue_request(OP_INSERT, pick_key(), pick_value(), 1'b0, ST_OK, '0, st);
		issue_request(OP_INSERT, pick_key(), pick_value(), 1'b0, ST_OK, '0, st);
		refusals = 0;
		while (refusals < 3) begin
			issue_request(OP_EXTRACT, pick_key(), pick_value(), 1'b0, ST_OK, '0, st);
			if (st == ST_EMPTY)
				refusals++;
		end
		random_mix(40);

		req_ch.valid <= 1'b0;
		waited = 0;
		while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_results.size() != 0)
			flag_mismatch($sformatf("%0d responses never arrived", awaited_results.size()));
		repeat (SETTLE_CYCS) @(posedge clk);

		$display("covered %0d transactions: %0d inserts (%0d refused as full), %0d extracts",
			n_insert + n_extract, n_insert, n_full, n_extract);
		$display("%0d extracts on an empty queue, peak occupancy %0d of %0d, %0d mismatches",
			n_empty, peak_fill, QCAP, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
